@@ rtl/pmc_pkg.sv @@
`timescale 1ns / 1ps

package pmc_pkg;

  localparam int MAX_NODES_DEFAULT = 16;
  localparam int ROW_W             = 16;
  localparam int COUNT_W           = 30;
  localparam int CFG_SIZE_W        = 5;
  localparam int APB_ADDR_W        = 2;
  localparam int APB_DATA_W        = 32;

  localparam logic [COUNT_W-1:0]    MODULUS          = 30'd1000000007;
  localparam logic [COUNT_W-1:0]    COUNT_ONE        = 30'd1;
  localparam logic [CFG_SIZE_W-1:0] SIZE_RESET       = 5'd16;
  localparam logic [APB_ADDR_W-1:0] ADDR_MATRIX_SIZE = 2'd0;

  typedef struct packed {
    logic busy;
    logic done;
  } fill_status_t;

endpackage

@@ rtl/pmc_count_ram.sv @@
`timescale 1ns / 1ps

module pmc_count_ram
  import pmc_pkg::*;
#(
  parameter int ADDR_W = MAX_NODES_DEFAULT
) (
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [COUNT_W-1:0] wdata,
  output logic [COUNT_W-1:0] rdata
);

  logic [COUNT_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/pmc_row_file.sv @@
`timescale 1ns / 1ps

module pmc_row_file
  import pmc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic                               wr_last,
  input  logic [ROW_W-1:0]                   wr_row,
  input  logic [$clog2(MAX_NODES+1)-1:0]     rd_idx,
  output logic [ROW_W-1:0]                   rd_row
);

  localparam int SZW  = $clog2(MAX_NODES + 1);
  localparam int IDXW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [SZW-1:0] MAX_CNT = SZW'(MAX_NODES);

  logic [ROW_W-1:0] rows [MAX_NODES];
  logic [SZW-1:0]   rows_loaded;
  logic [SZW-1:0]   rows_loaded_next;
  logic [SZW-1:0]   fill_rows;

  always_comb begin
    rows_loaded_next = rows_loaded;
    if (rows_loaded != MAX_CNT) begin
      rows_loaded_next = rows_loaded + SZW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
      fill_rows   <= '0;
    end else if (wr_en) begin
      if (wr_last) begin
        rows_loaded <= '0;
        fill_rows   <= rows_loaded_next;
      end else begin
        rows_loaded <= rows_loaded_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (rows_loaded != MAX_CNT)) begin
      rows[rows_loaded[IDXW-1:0]] <= wr_row;
    end
  end

  // rows past the loaded count read as empty
  assign rd_row = (rd_idx < fill_rows) ? rows[rd_idx[IDXW-1:0]] : '0;

endmodule

@@ rtl/pmc_fill_ctrl.sv @@
`timescale 1ns / 1ps

module pmc_fill_ctrl
  import pmc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           out_free,
  input  logic [$clog2(MAX_NODES+1)-1:0] size,
  output logic [$clog2(MAX_NODES+1)-1:0] row_idx,
  input  logic [ROW_W-1:0]               row_data,
  output logic [COUNT_W-1:0]             result,
  output fill_status_t                   status
);

  localparam int MW  = MAX_NODES;
  localparam int SZW = $clog2(MAX_NODES + 1);
  localparam int JW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  localparam logic [COUNT_W:0] MOD_EXT = {1'b0, MODULUS};

  logic [2:0]         state;
  logic [MW-1:0]      mask;
  logic [MW-1:0]      full;
  logic [MW-1:0]      allowed;
  logic [SZW-1:0]     j;
  logic [COUNT_W-1:0] sum;
  logic               rd_pend;
  logic [COUNT_W:0]   acc_raw;
  logic [COUNT_W-1:0] acc;
  logic               issue;

  logic               ram_en;
  logic               ram_we;
  logic [MW-1:0]      ram_addr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [COUNT_W-1:0] ram_rdata;

  always_comb begin
    for (int b = 0; b < MW; b++) begin
      full[b] = (b < int'(size));
    end
  end

  assign row_idx = size - SZW'($countones(mask));

  assign acc_raw = {1'b0, sum} + {1'b0, ram_rdata};
  assign acc     = (acc_raw >= MOD_EXT) ? COUNT_W'(acc_raw - MOD_EXT) : acc_raw[COUNT_W-1:0];

  assign issue = (state == S_RUN) && allowed[j[JW-1:0]];

  // reads and the write-back of one mask never share a cycle, and every
  // read address is a smaller mask that was written in an earlier pass
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = mask & ~(MW'(1) << j);
    ram_wdata = sum;
    case (state)
      S_INIT: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = '0;
        ram_wdata = COUNT_ONE;
      end
      S_RUN: begin
        ram_en = issue;
      end
      S_WRITE: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = mask;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  pmc_count_ram #(
    .ADDR_W (MW)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issue;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          state <= (full == '0) ? S_FINISH : S_SETUP;
        end
        S_SETUP: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (j == size - SZW'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          state <= (mask == full) ? S_FINISH : S_SETUP;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      sum <= acc;
    end
    case (state)
      S_INIT: begin
        mask   <= MW'(1);
        result <= COUNT_ONE;
      end
      S_SETUP: begin
        allowed <= mask & MW'(row_data);
        j       <= '0;
        sum     <= '0;
      end
      S_RUN: begin
        j <= j + SZW'(1);
      end
      S_WRITE: begin
        mask   <= mask + MW'(1);
        result <= sum;
      end
      default: begin
      end
    endcase
  end

  assign status.busy = (state != S_IDLE);
  assign status.done = (state == S_FINISH) && out_free;

endmodule

@@ rtl/perfect_matching_counter_top.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                   Payload
// item      item_valid / item_stall     row_bits[15:0], last_row
// result    result_valid / result_stall matching_count[29:0]
// config    APB (psel, penable, pwrite) paddr[1:0], pwdata, prdata (matrix_size at 0x0)
//
// A row without last_row is written to the row file. A last row starts the
// count, which steps through the subset masks on the single port of the
// subset table (one read or one write per cycle). The table needs no clear
// after reset: each entry is written before it is read. Items stall while a
// count runs or while its result waits for the output register.

module perfect_matching_counter_top
  import pmc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [ROW_W-1:0]      row_bits,
  input  logic                  last_row,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [COUNT_W-1:0]    matching_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SZW = $clog2(MAX_NODES + 1);

  logic [CFG_SIZE_W-1:0] matrix_size;
  logic [SZW-1:0]        eff_size;
  logic                  item_xfer;
  logic [SZW-1:0]        row_idx;
  logic [ROW_W-1:0]      row_data;
  logic [COUNT_W-1:0]    fill_result;
  fill_status_t          status;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MATRIX_SIZE) ? APB_DATA_W'(matrix_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_MATRIX_SIZE)) begin
      matrix_size <= pwdata[CFG_SIZE_W-1:0];
    end
  end

  assign eff_size = (int'(matrix_size) > MAX_NODES) ? SZW'(MAX_NODES) : SZW'(matrix_size);

  assign item_stall = status.busy;
  assign item_xfer  = item_valid && !item_stall;

  pmc_row_file #(
    .MAX_NODES (MAX_NODES)
  ) u_rows (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (item_xfer),
    .wr_last (last_row),
    .wr_row  (row_bits),
    .rd_idx  (row_idx),
    .rd_row  (row_data)
  );

  pmc_fill_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_fill (
    .clk      (clk),
    .rst      (rst),
    .start    (item_xfer && last_row),
    .out_free (!result_valid),
    .size     (eff_size),
    .row_idx  (row_idx),
    .row_data (row_data),
    .result   (fill_result),
    .status   (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (status.done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      matching_count <= fill_result;
    end
  end

endmodule
